FILE: src/sem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and helpers for the counting semaphore.
// No dependencies; used by every other file of the block except sem_chan_if.
package sem_pkg;

  localparam int TID_W  = 5;
  localparam int CNT_W  = 16;
  localparam int IC_W   = 15;
  localparam int RC_W   = 8;
  localparam int KIND_W = 3;
  localparam int OP_W   = 2;

  localparam logic signed [CNT_W-1:0] COUNT_TOP = 16'sd32767;

  localparam logic [OP_W-1:0] OP_WAIT    = 2'd0;
  localparam logic [OP_W-1:0] OP_SIGNAL  = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

  localparam logic [KIND_W-1:0] KIND_GRANTED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BLOCKED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SIGDONE  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_IGNORED  = 3'd5;

  typedef logic [IC_W-1:0] cfg_word_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [TID_W-1:0] thread_id;
    logic             timed;
    logic [RC_W-1:0]  release_count;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [TID_W-1:0]        thread_out;
    logic [RC_W-1:0]         released_total;
    logic signed [CNT_W-1:0] count_now;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic load;
    logic shift;
  } list_cmd_t;

  function automatic result_t mk_result(input logic [KIND_W-1:0] kind,
                                        input logic [TID_W-1:0] thr,
                                        input logic [RC_W-1:0] rel,
                                        input logic signed [CNT_W-1:0] cnt,
                                        input logic last);
    result_t r;
    r.kind           = kind;
    r.thread_out     = thr;
    r.released_total = rel;
    r.count_now      = cnt;
    r.last           = last;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/sem_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel carrying one word of a configurable payload type.
// Used for the request, result and configuration channels.
interface sem_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/counting_semaphore_with_timed_waits.sv
`timescale 1ns / 1ps
`default_nettype none
// Counting semaphore with an untimed FIFO and a timed list of waiting threads.
// Channels: req (sink) takes one word per operation: wait, signal or timeout.
// rsp (source) returns result words; the final word of an operation has last
// set. cfg (sink) writes initial_count, which reloads the count and empties
// both lists; it is taken only while no operation is in progress.
// Each operation runs alone. Steps from acceptance to the final result:
//   wait:    a decide step that emits the single result word
//   signal:  decide, one release step per waiter released, one step adding any
//            units left once both lists are empty (all at once), then the done word
//   timeout: decide, then a scan of the timed list up to the thread or the fill
// Signals release one waiter per cycle while rsp is not stalled; a timeout scans
// the timed cell row one entry per cycle. The next req word is taken in the cycle
// after the final result enters the output register, unless cfg is valid.
// Results pass through one output register; while rsp is stalled the sequencer
// holds at each step that emits a word and resumes when the register frees up.
// Reset (rst, synchronous): count 0, both lists empty, no result pending.
// No clearing pass is needed: list entries beyond the fill are never read.
module counting_semaphore_with_timed_waits #(
  parameter int MAX_THREADS = 32
) (
  input  logic       clk,
  input  logic       rst,
  sem_chan_if.sink   req,
  sem_chan_if.source rsp,
  sem_chan_if.sink   cfg
);
  import sem_pkg::*;

  localparam int IW = $clog2(MAX_THREADS);
  localparam int FW = $clog2(MAX_THREADS + 1);
  localparam logic [FW:0] CAP = (FW + 1)'(MAX_THREADS);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_SIGNAL = 4'b0100,
    S_SCAN   = 4'b1000
  } state_t;

  state_t                  state, state_next;
  logic [OP_W-1:0]         op, op_next;
  logic [TID_W-1:0]        tid, tid_next;
  logic                    timed, timed_next;
  logic [RC_W-1:0]         units, units_next;
  logic [RC_W-1:0]         released, released_next;
  logic signed [CNT_W-1:0] count, count_next;
  logic [FW-1:0]           fifo_fill, fifo_fill_next;
  logic [FW-1:0]           timed_fill, timed_fill_next;
  logic [FW-1:0]           scan, scan_next;
  result_t                 res, res_next;
  logic                    res_valid, res_valid_next;

  list_cmd_t        fifo_cmd, timed_cmd;
  logic [IW-1:0]    timed_shift_from;
  logic [TID_W-1:0] fifo_ids [MAX_THREADS];
  logic [TID_W-1:0] timed_ids [MAX_THREADS];

  logic                    emit_ok;
  logic [FW:0]             occ;
  logic signed [CNT_W-1:0] count_inc_sat;
  logic [IC_W+1:0]         bulk_sum;
  logic signed [CNT_W-1:0] bulk_count;

  assign emit_ok       = !res_valid || rsp.ready;
  assign occ           = {1'b0, fifo_fill} + {1'b0, timed_fill};
  assign count_inc_sat = (count < COUNT_TOP) ? count + 16'sd1 : count;
  assign bulk_sum      = (IC_W + 2)'(count[IC_W-1:0]) + (IC_W + 2)'(units);
  assign bulk_count    = (bulk_sum > (IC_W + 2)'(COUNT_TOP)) ? COUNT_TOP
                                                             : CNT_W'(bulk_sum);

  assign cfg.ready = (state == S_IDLE);
  assign req.ready = (state == S_IDLE) && !cfg.valid;
  assign rsp.valid = res_valid;
  assign rsp.data  = res;

  sem_list #(.DEPTH(MAX_THREADS), .IW(IW)) u_fifo (
    .clk        (clk),
    .cmd        (fifo_cmd),
    .load_idx   (fifo_fill[IW-1:0]),
    .shift_from ('0),
    .load_id    (tid),
    .ids        (fifo_ids)
  );

  sem_list #(.DEPTH(MAX_THREADS), .IW(IW)) u_timed (
    .clk        (clk),
    .cmd        (timed_cmd),
    .load_idx   (timed_fill[IW-1:0]),
    .shift_from (timed_shift_from),
    .load_id    (tid),
    .ids        (timed_ids)
  );

  always_comb begin
    state_next       = state;
    op_next          = op;
    tid_next         = tid;
    timed_next       = timed;
    units_next       = units;
    released_next    = released;
    count_next       = count;
    fifo_fill_next   = fifo_fill;
    timed_fill_next  = timed_fill;
    scan_next        = scan;
    res_next         = res;
    res_valid_next   = res_valid && !rsp.ready;
    fifo_cmd         = '0;
    timed_cmd        = '0;
    timed_shift_from = '0;

    case (state)
      S_IDLE: begin
        if (cfg.valid) begin
          count_next      = CNT_W'({1'b0, cfg.data});
          fifo_fill_next  = '0;
          timed_fill_next = '0;
        end else if (req.valid) begin
          op_next    = req.data.op;
          tid_next   = req.data.thread_id;
          timed_next = req.data.timed;
          units_next = (req.data.release_count == '0) ? RC_W'(1)
                                                      : req.data.release_count;
          state_next = S_DECIDE;
        end
      end

      S_DECIDE: begin
        case (op)
          OP_WAIT: begin
            if (emit_ok) begin
              res_valid_next = 1'b1;
              state_next     = S_IDLE;
              if (count > 16'sd0) begin
                count_next = count - 16'sd1;
                res_next   = mk_result(KIND_GRANTED, tid, '0, count - 16'sd1, 1'b1);
              end else if (occ >= CAP) begin
                res_next = mk_result(KIND_IGNORED, tid, '0, count, 1'b1);
              end else begin
                count_next = count - 16'sd1;
                if (timed) begin
                  timed_cmd.load  = 1'b1;
                  timed_fill_next = timed_fill + FW'(1);
                end else begin
                  fifo_cmd.load  = 1'b1;
                  fifo_fill_next = fifo_fill + FW'(1);
                end
                res_next = mk_result(KIND_BLOCKED, tid, '0, count - 16'sd1, 1'b1);
              end
            end
          end
          OP_SIGNAL: begin
            released_next = '0;
            state_next    = S_SIGNAL;
          end
          OP_TIMEOUT: begin
            scan_next  = '0;
            state_next = S_SCAN;
          end
          default: begin
            if (emit_ok) begin
              res_valid_next = 1'b1;
              res_next       = mk_result(KIND_IGNORED, tid, '0, count, 1'b1);
              state_next     = S_IDLE;
            end
          end
        endcase
      end

      S_SIGNAL: begin
        if (units == '0) begin
          if (emit_ok) begin
            res_valid_next = 1'b1;
            res_next       = mk_result(KIND_SIGDONE, '0, released, count, 1'b1);
            state_next     = S_IDLE;
          end
        end else if (fifo_fill != '0) begin
          if (emit_ok) begin
            fifo_cmd.shift = 1'b1;
            fifo_fill_next = fifo_fill - FW'(1);
            count_next     = count + 16'sd1;
            released_next  = released + RC_W'(1);
            units_next     = units - RC_W'(1);
            res_valid_next = 1'b1;
            res_next       = mk_result(KIND_RELEASED, fifo_ids[0],
                                       released + RC_W'(1), count + 16'sd1, 1'b0);
          end
        end else if (timed_fill != '0) begin
          if (emit_ok) begin
            timed_cmd.shift = 1'b1;
            timed_fill_next = timed_fill - FW'(1);
            count_next      = count + 16'sd1;
            released_next   = released + RC_W'(1);
            units_next      = units - RC_W'(1);
            res_valid_next  = 1'b1;
            res_next        = mk_result(KIND_RELEASED, timed_ids[0],
                                        released + RC_W'(1), count + 16'sd1, 1'b0);
          end
        end else begin
          count_next = bulk_count;
          units_next = '0;
        end
      end

      S_SCAN: begin
        timed_shift_from = scan[IW-1:0];
        if (scan >= timed_fill) begin
          if (emit_ok) begin
            res_valid_next = 1'b1;
            res_next       = mk_result(KIND_IGNORED, tid, '0, count, 1'b1);
            state_next     = S_IDLE;
          end
        end else if (timed_ids[scan[IW-1:0]] == tid) begin
          if (emit_ok) begin
            timed_cmd.shift = 1'b1;
            timed_fill_next = timed_fill - FW'(1);
            count_next      = count_inc_sat;
            res_valid_next  = 1'b1;
            res_next        = mk_result(KIND_TIMEOUT, tid, '0, count_inc_sat, 1'b1);
            state_next      = S_IDLE;
          end
        end else begin
          scan_next = scan + FW'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      fifo_fill  <= '0;
      timed_fill <= '0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      fifo_fill  <= fifo_fill_next;
      timed_fill <= timed_fill_next;
      res_valid  <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    tid      <= tid_next;
    timed    <= timed_next;
    units    <= units_next;
    released <= released_next;
    scan     <= scan_next;
    res      <= res_next;
  end

  a_count_tracks_waiters: assert property (@(posedge clk) disable iff (rst)
    (occ != '0) |-> (count + CNT_W'(occ) == 16'sd0))
    else $error("count does not match number of queued waiters");

  a_lists_bounded: assert property (@(posedge clk) disable iff (rst)
    occ <= CAP)
    else $error("waiter lists exceed capacity");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan <= timed_fill))
    else $error("timed list scan ran past the fill");

  a_signal_drains_fifo_first: assert property (@(posedge clk) disable iff (rst)
    (timed_cmd.shift && state == S_SIGNAL) |-> (fifo_fill == '0))
    else $error("timed waiter released while FIFO waiters remain");

endmodule
`default_nettype wire

FILE: src/sem_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One entry of a waiter list: holds a thread id, loads a new one or
// takes its right neighbor's id when the list closes a gap. Uses sem_pkg.
module sem_cell (
  input  logic                     clk,
  input  sem_pkg::list_cmd_t       cmd,
  input  logic [sem_pkg::TID_W-1:0] load_id,
  input  logic [sem_pkg::TID_W-1:0] right_id,
  output logic [sem_pkg::TID_W-1:0] id
);
  import sem_pkg::*;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id <= load_id;
    end else if (cmd.shift) begin
      id <= right_id;
    end
  end

endmodule
`default_nettype wire

FILE: src/sem_list.sv
`timescale 1ns / 1ps
`default_nettype none
// Ordered row of sem_cell entries, head at entry 0. Loads one entry at an
// index and closes a gap by shifting entries at and above an index left.
module sem_list #(
  parameter int DEPTH = 32,
  parameter int IW    = 5
) (
  input  logic                      clk,
  input  sem_pkg::list_cmd_t        cmd,
  input  logic [IW-1:0]             load_idx,
  input  logic [IW-1:0]             shift_from,
  input  logic [sem_pkg::TID_W-1:0] load_id,
  output logic [sem_pkg::TID_W-1:0] ids [DEPTH]
);
  import sem_pkg::*;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    list_cmd_t        cell_cmd;
    logic [TID_W-1:0] right_id;

    assign cell_cmd.load  = cmd.load && (load_idx == IW'(k));
    assign cell_cmd.shift = cmd.shift && (IW'(k) >= shift_from);

    if (k == DEPTH - 1) begin : g_end
      assign right_id = ids[k];
    end else begin : g_mid
      assign right_id = ids[k+1];
    end

    sem_cell u_cell (
      .clk      (clk),
      .cmd      (cell_cmd),
      .load_id  (load_id),
      .right_id (right_id),
      .id       (ids[k])
    );
  end

endmodule
`default_nettype wire

FILE: verif/counting_semaphore_with_timed_waits_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the counting semaphore: watches the req, cfg and rsp handshakes,
// predicts the result words of every accepted operation and compares them in order.
// Depends on sem_pkg for the word layouts and codes.
module counting_semaphore_with_timed_waits_checker #(
  parameter int MAX_THREADS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_ready,
  input  sem_pkg::item_t       req_data,
  input  logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  sem_pkg::result_t     rsp_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  sem_pkg::cfg_word_t   cfg_data,
  output int                   errors,
  output int                   pending,
  output int                   ops_taken,
  output int                   words_checked
);
  import sem_pkg::*;

  int               count_q;
  logic [TID_W-1:0] fifo_ids [MAX_THREADS];
  int               fifo_head;
  int               fifo_fill;
  logic [TID_W-1:0] timed_ids [MAX_THREADS];
  int               timed_fill;
  result_t          expected_words [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 40)
      $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic add_word(input logic [KIND_W-1:0] kind, input logic [TID_W-1:0] thr,
                          input logic [RC_W-1:0] rel, input logic last);
    result_t w;
    w.kind           = kind;
    w.thread_out     = thr;
    w.released_total = rel;
    w.count_now      = count_q[CNT_W-1:0];
    w.last           = last;
    expected_words.push_back(w);
  endtask

  task automatic apply_op(input item_t it);
    int               units;
    int               pos;
    logic [RC_W-1:0]  freed;
    logic [TID_W-1:0] who;
    case (it.op)
      OP_WAIT: begin
        if (count_q > 0) begin
          count_q--;
          add_word(KIND_GRANTED, it.thread_id, '0, 1'b1);
        end else if (fifo_fill + timed_fill >= MAX_THREADS) begin
          add_word(KIND_IGNORED, it.thread_id, '0, 1'b1);
        end else begin
          count_q--;
          if (it.timed) begin
            timed_ids[timed_fill] = it.thread_id;
            timed_fill++;
          end else begin
            fifo_ids[(fifo_head + fifo_fill) % MAX_THREADS] = it.thread_id;
            fifo_fill++;
          end
          add_word(KIND_BLOCKED, it.thread_id, '0, 1'b1);
        end
      end
      OP_SIGNAL: begin
        units = (it.release_count == 0) ? 1 : int'(it.release_count);
        freed = '0;
        for (int u = 0; u < units; u++) begin
          if (fifo_fill > 0) begin
            who = fifo_ids[fifo_head];
            fifo_head = (fifo_head + 1) % MAX_THREADS;
            fifo_fill--;
            count_q++;
            freed++;
            add_word(KIND_RELEASED, who, freed, 1'b0);
          end else if (timed_fill > 0) begin
            who = timed_ids[0];
            for (int i = 1; i < timed_fill; i++)
              timed_ids[i-1] = timed_ids[i];
            timed_fill--;
            count_q++;
            freed++;
            add_word(KIND_RELEASED, who, freed, 1'b0);
          end else if (count_q < COUNT_TOP) begin
            count_q++;
          end
        end
        add_word(KIND_SIGDONE, '0, freed, 1'b1);
      end
      OP_TIMEOUT: begin
        pos = -1;
        for (int i = 0; i < timed_fill; i++)
          if (pos < 0 && timed_ids[i] == it.thread_id)
            pos = i;
        if (pos < 0) begin
          add_word(KIND_IGNORED, it.thread_id, '0, 1'b1);
        end else begin
          for (int i = pos + 1; i < timed_fill; i++)
            timed_ids[i-1] = timed_ids[i];
          timed_fill--;
          if (count_q < COUNT_TOP)
            count_q++;
          add_word(KIND_TIMEOUT, it.thread_id, '0, 1'b1);
        end
      end
      default: begin
        add_word(KIND_IGNORED, it.thread_id, '0, 1'b1);
      end
    endcase
  endtask

  task automatic check_word(input result_t got);
    result_t want;
    words_checked++;
    if (expected_words.size() == 0) begin
      report_mismatch("word with nothing expected, kind", int'(got.kind), -1);
    end else begin
      want = expected_words.pop_front();
      if (got.kind != want.kind)
        report_mismatch("kind", int'(got.kind), int'(want.kind));
      if (got.thread_out != want.thread_out)
        report_mismatch("thread_out", int'(got.thread_out), int'(want.thread_out));
      if (got.released_total != want.released_total)
        report_mismatch("released_total", int'(got.released_total),
                        int'(want.released_total));
      if (got.count_now !== want.count_now)
        report_mismatch("count_now", int'(got.count_now), int'(want.count_now));
      if (got.last !== want.last)
        report_mismatch("last", int'(got.last), int'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      count_q    = 0;
      fifo_head  = 0;
      fifo_fill  = 0;
      timed_fill = 0;
      expected_words.delete();
      pending    = 0;
    end else begin
      if (rsp_valid && rsp_ready)
        check_word(rsp_data);
      if (cfg_valid && cfg_ready) begin
        count_q    = int'(cfg_data);
        fifo_head  = 0;
        fifo_fill  = 0;
        timed_fill = 0;
      end
      if (req_valid && req_ready) begin
        apply_op(req_data);
        ops_taken++;
      end
      pending = expected_words.size();
    end
  end

endmodule

FILE: verif/counting_semaphore_with_timed_waits_tb.sv
`timescale 1ns / 1ps
// Top of the semaphore testbench: clock, reset, operation and count-load stimulus,
// response back-pressure and the verdict. Depends on sem_pkg, sem_chan_if, the semaphore and the checker.
module counting_semaphore_with_timed_waits_tb;
  import sem_pkg::*;

  localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;

  typedef enum {RX_OPEN, RX_SPARSE_STALL, RX_EVERY_THIRD, RX_TRICKLE} rx_mode_t;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   ops_taken;
  int   words_checked;
  int   burst_left;
  int   hold_asks;
  int   loads_done;
  logic [TID_W-1:0] recent_timed [$];

  sem_chan_if #(.payload_t(item_t))     req_ch ();
  sem_chan_if #(.payload_t(result_t))   rsp_ch ();
  sem_chan_if #(.payload_t(cfg_word_t)) cfg_ch ();

  counting_semaphore_with_timed_waits #(.MAX_THREADS(32)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  counting_semaphore_with_timed_waits_checker #(.MAX_THREADS(32)) scoreboard (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_ch.valid),
    .req_ready     (req_ch.ready),
    .req_data      (req_ch.data),
    .rsp_valid     (rsp_ch.valid),
    .rsp_ready     (rsp_ch.ready),
    .rsp_data      (rsp_ch.data),
    .cfg_valid     (cfg_ch.valid),
    .cfg_ready     (cfg_ch.ready),
    .cfg_data      (cfg_ch.data),
    .errors        (errors),
    .pending       (pending),
    .ops_taken     (ops_taken),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic item_t make_op(input logic [OP_W-1:0] op, input logic [TID_W-1:0] tid,
                                    input logic timed, input logic [RC_W-1:0] rc);
    item_t it;
    it.op            = op;
    it.thread_id     = tid;
    it.timed         = timed;
    it.release_count = rc;
    return it;
  endfunction

  function automatic logic [TID_W-1:0] pick_tid();
    return ($urandom_range(0, 9) < 7) ? TID_W'($urandom_range(0, 7))
                                      : TID_W'($urandom_range(0, 31));
  endfunction

  task automatic push_op(input item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= it;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic load_count(input cfg_word_t v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    loads_done++;
    @(negedge clk);
  endtask

  // response side: its own stall pattern, plus long holds on request
  initial begin
    int       hold_left;
    int       mode_left;
    int       holds_seen;
    int       tick;
    rx_mode_t rx_mode;
    rsp_ch.ready = 1'b0;
    hold_left    = 0;
    mode_left    = 0;
    holds_seen   = 0;
    tick         = 0;
    rx_mode      = RX_OPEN;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_asks != holds_seen) begin
        holds_seen = hold_asks;
        hold_left  = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (rx_mode)
          RX_OPEN:         rsp_ch.ready <= 1'b1;
          RX_SPARSE_STALL: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_EVERY_THIRD:  rsp_ch.ready <= (tick % 3 == 0);
          default:         rsp_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin
    item_t            it;
    int               r;
    logic [TID_W-1:0] tid;
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    burst_left   = 0;
    hold_asks    = 0;
    loads_done   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: grants, both lists, repeated waiter, unknown timeout and op
    load_count(15'd2);
    push_op(make_op(OP_WAIT, 5'd0, 1'b0, 8'd0));
    push_op(make_op(OP_WAIT, 5'd31, 1'b1, 8'd0));
    push_op(make_op(OP_WAIT, 5'd5, 1'b1, 8'd0));
    push_op(make_op(OP_WAIT, 5'd5, 1'b1, 8'd0));
    push_op(make_op(OP_WAIT, 5'd9, 1'b0, 8'd255));
    push_op(make_op(OP_TIMEOUT, 5'd5, 1'b0, 8'd0));
    push_op(make_op(OP_TIMEOUT, 5'd17, 1'b1, 8'd0));
    push_op(make_op(OP_UNDEFINED, 5'd31, 1'b1, 8'd255));
    push_op(make_op(OP_SIGNAL, 5'd0, 1'b0, 8'd0));
    push_op(make_op(OP_SIGNAL, 5'd31, 1'b1, 8'd255));
    push_op(make_op(OP_TIMEOUT, 5'd5, 1'b0, 8'd0));
    push_op(make_op(OP_WAIT, 5'd31, 1'b1, 8'd255));
    settle();

    // count pinned at its top
    load_count(15'h7FFF);
    push_op(make_op(OP_SIGNAL, 5'd3, 1'b0, 8'd3));
    push_op(make_op(OP_WAIT, 5'd3, 1'b0, 8'd0));
    push_op(make_op(OP_SIGNAL, 5'd0, 1'b0, 8'd1));
    push_op(make_op(OP_SIGNAL, 5'd0, 1'b0, 8'd0));
    settle();

    // fill both lists behind a long response hold, overflow once, then release all
    load_count(15'd0);
    hold_asks++;
    burst_left = 64;
    for (int i = 0; i < 33; i++)
      push_op(make_op(OP_WAIT, TID_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                      RC_W'($urandom)));
    push_op(make_op(OP_SIGNAL, TID_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                    8'd255));
    settle();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       load_count(15'd0);
        1:       load_count(15'd1);
        2:       load_count(15'd4);
        3:       load_count(IC_W'($urandom_range(0, 3)));
        default: load_count(IC_W'($urandom_range(0, 12)));
      endcase
      recent_timed.delete();
      for (int n = 0; n < 56; n++) begin
        r = $urandom_range(0, 99);
        it = make_op(OP_WAIT, pick_tid(), 1'($urandom_range(0, 1)), RC_W'($urandom));
        if (r < 50) begin
          if (it.timed) begin
            recent_timed.push_back(it.thread_id);
            if (recent_timed.size() > 16)
              void'(recent_timed.pop_front());
          end
        end else if (r < 70) begin
          it.op = OP_SIGNAL;
          r = $urandom_range(0, 99);
          if (r < 40)
            it.release_count = '0;
          else if (r < 96)
            it.release_count = RC_W'($urandom_range(1, 2));
          else
            it.release_count = RC_W'($urandom_range(0, 255));
        end else if (r < 95) begin
          it.op = OP_TIMEOUT;
          if (recent_timed.size() > 0 && $urandom_range(0, 4) != 0) begin
            tid = recent_timed[$urandom_range(0, recent_timed.size() - 1)];
            it.thread_id = tid;
          end
        end else begin
          it.op = OP_UNDEFINED;
        end
        push_op(it);
      end
      settle();
    end

    repeat (8) @(negedge clk);
    $display("Summary: %0d operations taken, %0d result words checked, %0d count loads",
             ops_taken, words_checked, loads_done);
    $display("Run included full wait lists, a saturated count and a long response hold.");
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: counting_semaphore_with_timed_waits.f
src/sem_pkg.sv
src/sem_chan_if.sv
src/sem_cell.sv
src/sem_list.sv
src/counting_semaphore_with_timed_waits.sv
verif/counting_semaphore_with_timed_waits_checker.sv
verif/counting_semaphore_with_timed_waits_tb.sv
